@@ hdl/bcds_pkg.sv @@
// Package with types, constants and codes for the box collision and depth scale engine.
package bcds_pkg;

    localparam int RamBytes   = 2048;
    localparam int AddrW      = 11;
    localparam int MaxObjects = 64;
    localparam int EntrySize  = 14;
    localparam int EntryBase  = 16;
    localparam int NumEntries = MaxObjects - 1;
    localparam int EntryW     = $clog2(MaxObjects);
    localparam int FieldW     = 3;

    localparam logic [15:0] DefaultNear = 16'h6400;
    localparam logic [7:0]  ModeAll     = 8'h0c;
    localparam logic [15:0] SpecW       = 16'h0058;
    localparam logic [15:0] SpecD       = 16'h0004;
    localparam logic [15:0] SpecH       = 16'h0010;
    localparam logic [15:0] SpecY       = 16'h0030;

    typedef enum logic [1:0] {
        REQ_READ  = 2'd0,
        REQ_WRITE = 2'd1,
        REQ_START = 2'd2,
        REQ_NONE  = 2'd3
    } t_req;

    typedef struct packed {
        logic [1:0]       req_type;
        logic [AddrW-1:0] address;
        logic [7:0]       write_data;
    } t_in_item;

    typedef struct packed {
        logic [7:0] read_data;
        logic       done_res;
    } t_out_item;

    // Divider handshake.
    typedef struct packed {
        logic        start;
        logic [23:0] dividend;
        logic [15:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [15:0] quotient;
    } t_div_rsp;

    typedef enum logic [4:0] {
        S_IDLE,
        S_RD_WAIT,
        S_OUT,
        S_CLEAR,
        S_JOB_RD,
        S_JOB_WAIT,
        S_JOB_HDR,
        S_COL_RD,
        S_COL_WAIT,
        S_COL_CAP,
        S_COL_EVAL,
        S_COL_WR,
        S_DEP_RD,
        S_DEP_WAIT,
        S_DEP_CAP,
        S_DEP_DIV,
        S_DEP_WR,
        S_ZERO
    } t_state;

endpackage

@@ hdl/box_collision_and_depth_scale_engine.sv @@
// Top level of the box collision and depth scale engine.
// A write or an ignored item passes through S_OUT, a read through S_RD_WAIT and then S_OUT,
// before its result is registered; the next item is taken only once the result has left.
// A start reads the 16 header bytes; a collision job then reads 13 bytes of each of the 63
// entries, while a depth job divides each word and clears the bytes after the last word.
// After reset a clearing pass writes zero to all 2048 bytes, during which no item is accepted.
// Reset sets the state, pointers, hit flag and output valid; data registers are not reset.
module box_collision_and_depth_scale_engine (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  bcds_pkg::t_in_item   i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output bcds_pkg::t_out_item  o_out_item
);
    import bcds_pkg::*;

    // The addressable state is one byte RAM with one port and a registered read.
    logic [7:0] mem [RamBytes];
    logic [7:0] r_rdata;
    logic       mem_we;
    logic [AddrW-1:0] mem_addr;
    logic [7:0] mem_wdata;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
        r_rdata <= mem[mem_addr];
    end

    t_state r_state, n_state;
    logic [AddrW:0]   r_ptr, n_ptr;     // general byte pointer, one bit wider for end test
    logic [3:0]       r_sub, n_sub;     // byte within an entry, or half of a depth word
    logic [EntryW-1:0] r_ent, n_ent;
    logic [7:0]       r_hdr [16];       // header bytes 0 to 15 captured at job start
    logic [7:0]       r_eb  [13];       // bytes of the current entry
    logic [7:0]       r_job;
    logic             r_hit, n_hit;
    logic [AddrW-1:0] r_end;            // first byte to be cleared in the depth job
    logic [15:0]      r_word;
    logic             r_out_valid, n_out_valid;
    t_out_item        r_out, n_out;
    t_in_item         r_req;
    logic             accept;
    logic             hdr_cap, ent_cap, word_cap;
    t_div_req         div_req;
    t_div_rsp         div_rsp;

    bcds_divider u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (div_req),
        .o_rsp  (div_rsp)
    );

    // Header words of the reference box and of the depth job, and words of the current entry.
    logic [15:0] x1, w1, z1, d1, y1, h1, x2, w2, z2, d2, y2, h2, h2e;
    logic [15:0] cnt_raw, near_raw, near;
    logic [6:0]  cnt;
    logic        all_mode, active, ov_x, ov_z, ov_y;
    logic [AddrW-1:0] ent_base;

    assign x1 = {r_hdr[3], r_hdr[4]};
    assign w1 = {r_hdr[5], r_hdr[6]};
    assign z1 = {r_hdr[7], r_hdr[8]};
    assign d1 = {r_hdr[9], r_hdr[10]};
    assign y1 = {r_hdr[11], r_hdr[12]};
    assign h1 = {r_hdr[13], r_hdr[14]};
    assign x2 = {r_eb[1], r_eb[2]};
    assign w2 = {r_eb[3], r_eb[4]};
    assign z2 = {r_eb[5], r_eb[6]};
    assign d2 = {r_eb[7], r_eb[8]};
    assign y2 = {r_eb[9], r_eb[10]};
    assign h2 = {r_eb[11], r_eb[12]};
    assign h2e = (w2 == SpecW && d2 == SpecD && h2 == SpecH && y2 == SpecY) ? y2 : h2;
    assign all_mode = (r_hdr[1] == ModeAll);
    assign active   = (r_eb[0] != 8'd0) || all_mode;
    assign cnt_raw  = {r_hdr[0], r_hdr[1]};
    assign near_raw = {r_hdr[2], r_hdr[3]};
    assign near     = (near_raw == 16'd0) ? DefaultNear : near_raw;
    assign cnt      = (cnt_raw > 16'(MaxObjects)) ? 7'(MaxObjects) : cnt_raw[6:0];
    assign ent_base = AddrW'(EntryBase + EntrySize * int'(r_ent));

    function automatic logic overlap(input logic [15:0] c1, input logic [15:0] e1,
                                     input logic [15:0] c2, input logic [15:0] e2);
        logic [15:0] dd;
        logic [16:0] ss;
        begin
            dd = (c1 >= c2) ? (c1 - c2) : (c2 - c1);
            ss = {1'b0, e1} + {1'b0, e2};
            return {1'b0, dd} < ss;
        end
    endfunction

    assign ov_x = overlap(x1, w1, x2, w2);
    assign ov_z = overlap(z1, d1, z2, d2);
    assign ov_y = overlap(y1, h1, y2, h2e);

    assign accept     = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE) || r_out_valid;

    // Next state.
    always_comb begin
        n_state = r_state;
        n_ptr   = r_ptr;
        n_sub   = r_sub;
        n_ent   = r_ent;
        n_hit   = r_hit;
        case (r_state)
            S_CLEAR: begin
                n_ptr = r_ptr + 1'b1;
                if (r_ptr == (AddrW+1)'(RamBytes - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    case (t_req'(i_in_item.req_type))
                        REQ_READ: n_state = S_RD_WAIT;
                        REQ_START: begin
                            n_state = S_JOB_RD;
                            n_ptr   = '0;
                        end
                        default: n_state = S_OUT;
                    endcase
                end
            end
            S_RD_WAIT: n_state = S_OUT;
            S_OUT:     n_state = S_IDLE;
            // Header capture: bytes 0 to 15 are read in turn, each through S_JOB_RD and S_JOB_WAIT.
            S_JOB_RD:   n_state = S_JOB_WAIT;
            S_JOB_WAIT: begin
                n_ptr = r_ptr + 1'b1;
                if (r_ptr[3:0] == 4'd15) begin
                    n_state = S_JOB_HDR;
                end else begin
                    n_state = S_JOB_RD;
                end
            end
            S_JOB_HDR: begin
                n_ent = '0;
                n_sub = '0;
                n_hit = 1'b0;
                n_ptr = (AddrW+1)'(4);
                if (r_job == 8'd1) begin
                    n_state = S_COL_RD;
                end else if (r_job > 8'd1) begin
                    n_state = (cnt == 7'd0) ? S_ZERO : S_DEP_RD;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_COL_RD:   n_state = S_COL_WAIT;
            S_COL_WAIT: n_state = S_COL_CAP;
            S_COL_CAP: begin
                if (r_sub == 4'd12) begin
                    n_state = S_COL_EVAL;
                end else begin
                    n_sub   = r_sub + 4'd1;
                    n_state = S_COL_RD;
                end
            end
            S_COL_EVAL: begin
                n_state = S_COL_WR;
                n_sub   = '0;
            end
            S_COL_WR: begin
                n_sub = '0;
                if (active && ov_x && ov_z && ov_y) begin
                    n_hit = 1'b1;
                end
                if (r_ent == EntryW'(NumEntries - 1)) begin
                    n_state = S_OUT;
                end else begin
                    n_ent   = r_ent + 1'b1;
                    n_state = S_COL_RD;
                end
            end
            S_DEP_RD:   n_state = S_DEP_WAIT;
            S_DEP_WAIT: n_state = S_DEP_CAP;
            S_DEP_CAP: begin
                if (r_sub[0]) begin
                    n_state = S_DEP_DIV;
                end else begin
                    n_sub   = 4'd1;
                    n_ptr   = r_ptr + 1'b1;
                    n_state = S_DEP_RD;
                end
            end
            S_DEP_DIV: begin
                if (div_rsp.done) begin
                    n_state = S_DEP_WR;
                    n_sub   = 4'd0;
                    n_ptr   = r_ptr - 1'b1;
                end
            end
            S_DEP_WR: begin
                n_ptr = r_ptr + 1'b1;
                if (r_sub[0]) begin
                    n_sub = 4'd0;
                    if (r_ptr[AddrW-1:0] + 1'b1 == r_end) begin
                        n_state = S_ZERO;
                    end else begin
                        n_state = S_DEP_RD;
                    end
                end else begin
                    n_sub = 4'd1;
                end
            end
            S_ZERO: begin
                n_ptr = r_ptr + 1'b1;
                if (r_ptr == (AddrW+1)'(RamBytes - 1)) begin
                    n_state = S_OUT;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Memory port and outputs.
    always_comb begin
        mem_we       = 1'b0;
        mem_addr     = r_ptr[AddrW-1:0];
        mem_wdata    = 8'd0;
        hdr_cap      = 1'b0;
        ent_cap      = 1'b0;
        word_cap     = 1'b0;
        div_req      = '0;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out        = r_out;
        case (r_state)
            S_CLEAR: mem_we = 1'b1;
            S_IDLE: begin
                mem_addr = i_in_item.address;
                if (accept && t_req'(i_in_item.req_type) == REQ_WRITE) begin
                    mem_we    = 1'b1;
                    mem_wdata = i_in_item.write_data;
                end
            end
            // Keep the read address so the byte is still in the read register at S_OUT.
            S_RD_WAIT: mem_addr = r_req.address;
            S_OUT: begin
                n_out_valid      = 1'b1;
                n_out.read_data  = (t_req'(r_req.req_type) == REQ_READ) ? r_rdata : 8'd0;
                n_out.done_res   = (t_req'(r_req.req_type) == REQ_START);
            end
            S_JOB_WAIT: hdr_cap = 1'b1;
            S_COL_RD:   mem_addr = ent_base + AddrW'(r_sub);
            S_COL_WAIT: mem_addr = ent_base + AddrW'(r_sub);
            S_COL_CAP:  ent_cap = 1'b1;
            S_COL_WR: begin
                mem_addr = ent_base + AddrW'(13);
                if (active) begin
                    mem_we    = 1'b1;
                    mem_wdata = (ov_x && ov_z && ov_y) ? 8'd0 : 8'd1;
                end
            end
            S_DEP_CAP: word_cap = 1'b1;
            S_DEP_DIV: begin
                div_req.start    = !div_rsp.busy && !div_rsp.done;
                div_req.dividend = {r_word, 8'd0};
                div_req.divisor  = near;
            end
            S_DEP_WR: begin
                mem_we    = 1'b1;
                mem_wdata = r_sub[0] ? div_rsp.quotient[7:0] : div_rsp.quotient[15:8];
            end
            S_ZERO: begin
                if (r_ptr[AddrW-1:0] >= r_end) begin
                    mem_we = 1'b1;
                end
            end
            default: ;
        endcase
        // A hit at any entry clears byte 15; done here once at the end of the scan.
        if (r_state == S_OUT && r_hit && t_req'(r_req.req_type) == REQ_START) begin
            mem_we   = 1'b1;
            mem_addr = AddrW'(15);
        end
    end

    // The divider must not restart on the cycle it finishes; its done flag covers that.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_ptr       <= '0;
            r_sub       <= '0;
            r_ent       <= '0;
            r_hit       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ptr       <= n_ptr;
            r_sub       <= n_sub;
            r_ent       <= n_ent;
            r_hit       <= n_hit;
            r_out_valid <= n_out_valid;
        end
        r_out <= n_out;
        if (accept) begin
            r_req <= i_in_item;
        end
        if (hdr_cap) begin
            r_hdr[r_ptr[3:0]] <= r_rdata;
            if (r_ptr[3:0] == 4'd2) begin
                r_job <= r_rdata;
            end
        end
        if (ent_cap) begin
            r_eb[r_sub] <= r_rdata;
        end
        if (word_cap) begin
            if (r_sub[0]) begin
                r_word[7:0] <= r_rdata;
            end else begin
                r_word[15:8] <= r_rdata;
            end
        end
        if (r_state == S_JOB_HDR) begin
            r_end <= AddrW'(4 + 2 * int'(cnt));
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

`ifndef NO_ASSERTIONS
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> r_state == S_IDLE) else $error("item accepted while busy");
    a_out_after_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |=> r_out_valid) else $error("result not presented");
    a_no_clear_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> mem_wdata == 8'd0) else $error("clear writes data");
    a_done_only_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.done_res) |-> r_out.read_data == 8'd0)
        else $error("done with data");
`endif

endmodule

@@ hdl/bcds_divider.sv @@
// Restoring divider producing one quotient bit per cycle (24 by 16 bits).
module bcds_divider (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bcds_pkg::t_div_req i_req,
    output bcds_pkg::t_div_rsp o_rsp
);
    import bcds_pkg::*;

    logic [23:0] r_quo, n_quo;
    logic [16:0] r_rem, n_rem;
    logic [15:0] r_div;
    logic [4:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [16:0] trial;
    logic [16:0] shifted;

    always_comb begin
        n_quo   = r_quo;
        n_rem   = r_rem;
        n_cnt   = r_cnt;
        n_busy  = r_busy;
        n_done  = 1'b0;
        shifted = {r_rem[15:0], r_quo[23]};
        trial   = shifted - {1'b0, r_div};
        if (i_req.start) begin
            n_quo  = i_req.dividend;
            n_rem  = '0;
            n_cnt  = 5'd0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (!trial[16]) begin
                n_rem = trial;
                n_quo = {r_quo[22:0], 1'b1};
            end else begin
                n_rem = shifted;
                n_quo = {r_quo[22:0], 1'b0};
            end
            n_cnt = r_cnt + 5'd1;
            if (r_cnt == 5'd23) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        if (i_req.start) begin
            r_div <= i_req.divisor;
        end
    end

    assign o_rsp.busy     = r_busy;
    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo[15:0];

`ifndef NO_ASSERTIONS
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy)) else $error("divider done without busy");
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy) else $error("divider done while busy");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_cnt < 5'd24) else $error("divider count overrun");
`endif

endmodule
